// ===== hdl/g2e_pkg.sv =====
// shared constants, tables and types of the geodetic to ecef converter
`default_nettype none
package g2e_pkg;

   localparam int ANGLE_BITS_DEF = 32;
   localparam int HEIGHT_W       = 28;
   localparam int COORD_W        = 36;
   localparam int SEL_W          = 2;

   localparam logic [SEL_W-1:0] ELL_CORREGO  = 2'd0;
   localparam logic [SEL_W-1:0] ELL_SAD69    = 2'd1;
   localparam logic [SEL_W-1:0] ELL_SIRGAS   = 2'd2;
   localparam logic [SEL_W-1:0] ELL_RESET    = ELL_SIRGAS;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 52;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // flattening in Q40 and first eccentricity squared in Q40
   localparam logic [127:0] F_CORREGO = (128'd1 << 40) / 128'd297;
   localparam logic [127:0] F_SAD69   = (128'd4 << 40) / 128'd1193;
   localparam logic [127:0] F_SIRGAS  = (128'd1000000000 << 40) / 128'd298257222101;
   localparam logic [127:0] E2W_CORREGO = 128'd2 * F_CORREGO - ((F_CORREGO * F_CORREGO) >> 40);
   localparam logic [127:0] E2W_SAD69   = 128'd2 * F_SAD69 - ((F_SAD69 * F_SAD69) >> 40);
   localparam logic [127:0] E2W_SIRGAS  = 128'd2 * F_SIRGAS - ((F_SIRGAS * F_SIRGAS) >> 40);
   localparam logic [33:0] E2_CORREGO = E2W_CORREGO[33:0];
   localparam logic [33:0] E2_SAD69   = E2W_SAD69[33:0];
   localparam logic [33:0] E2_SIRGAS  = E2W_SIRGAS[33:0];

   typedef struct packed {
      logic signed [31:0]         slat;
      logic signed [31:0]         clat;
      logic signed [31:0]         slon;
      logic signed [31:0]         clon;
      logic signed [HEIGHT_W-1:0] height;
   } trig_type;

   function automatic logic [32:0] semi_major(input logic [SEL_W-1:0] sel);
      logic [32:0] a;
      case (sel)
         ELL_CORREGO: a = 33'd6378388000;
         ELL_SAD69:   a = 33'd6378160000;
         default:     a = 33'd6378137000;
      endcase
      return a;
   endfunction

   function automatic logic [33:0] ecc_sq(input logic [SEL_W-1:0] sel);
      logic [33:0] e;
      case (sel)
         ELL_CORREGO: e = E2_CORREGO;
         ELL_SAD69:   e = E2_SAD69;
         default:     e = E2_SIRGAS;
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/g2e_cordic.sv =====
// pipelined rotation cordic giving sine and cosine of a binary angle
`default_nettype none
module g2e_cordic (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        turn,
   output logic signed [31:0]      sin_q,
   output logic signed [31:0]      cos_q
);
   import g2e_pkg::*;

   logic [31:0]        turn_off;
   logic [1:0]         quad;
   logic [31:0]        ru;
   logic [1:0]         quad_ff [CORDIC_STEPS+1];
   logic signed [31:0] x_ff [CORDIC_STEPS+1];
   logic signed [31:0] y_ff [CORDIC_STEPS+1];
   logic signed [31:0] z_ff [CORDIC_STEPS+1];
   logic signed [31:0] sin_ff, cos_ff;

   assign turn_off = turn + 32'h2000_0000;
   assign quad     = turn_off[31:30];
   assign ru       = turn - {quad, 30'd0};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= signed'(ru);
         quad_ff[0] <= quad;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - signed'(ATAN_TURN[i]);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + signed'(ATAN_TURN[i]);
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // undo the quarter-turn fold
   always_ff @(posedge clock) begin
      if (en) begin
         case (quad_ff[CORDIC_STEPS])
            2'd0: begin
               cos_ff <= x_ff[CORDIC_STEPS];
               sin_ff <= y_ff[CORDIC_STEPS];
            end
            2'd1: begin
               cos_ff <= -y_ff[CORDIC_STEPS];
               sin_ff <= x_ff[CORDIC_STEPS];
            end
            2'd2: begin
               cos_ff <= -x_ff[CORDIC_STEPS];
               sin_ff <= -y_ff[CORDIC_STEPS];
            end
            default: begin
               cos_ff <= y_ff[CORDIC_STEPS];
               sin_ff <= -x_ff[CORDIC_STEPS];
            end
         endcase
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule
`default_nettype wire

// ===== hdl/g2e_smul.sv =====
// two-stage signed multiply by a q30 factor, truncated toward zero
`default_nettype none
module g2e_smul #(
   parameter int A_W = 52
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic signed [A_W-1:0] a,
   input  wire logic signed [31:0]  b,
   output logic signed [A_W+1:0]    prod
);
   localparam int LO_W = A_W / 2;
   localparam int HI_W = A_W - LO_W;

   logic [A_W-1:0]        mag_a;
   logic [31:0]           mag_b;
   logic [LO_W+31:0]      lo_ff;
   logic [HI_W+31:0]      hi_ff;
   logic                  neg_ff;
   logic [A_W+31:0]       sum;
   logic [A_W+1:0]        mag_p;
   logic signed [A_W+1:0] prod_ff;

   assign mag_a = a[A_W-1] ? unsigned'(-a) : unsigned'(a);
   assign mag_b = b[31] ? unsigned'(-b) : unsigned'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff  <= (LO_W+32)'(mag_a[LO_W-1:0]) * (LO_W+32)'(mag_b);
         hi_ff  <= (HI_W+32)'(mag_a[A_W-1:LO_W]) * (HI_W+32)'(mag_b);
         neg_ff <= a[A_W-1] ^ b[31];
      end
   end

   assign sum   = {hi_ff, LO_W'(0)} + (A_W+32)'(lo_ff);
   assign mag_p = sum[A_W+31:30];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= neg_ff ? -signed'(mag_p) : signed'(mag_p);
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== hdl/geodetic_to_ecef_unit.sv =====
// top level: geodetic latitude, longitude and height to earth-centred x, y, z
`default_nettype none
// Converts one point per clock while not stalled: latitude and longitude
// as binary angles (2^(ANGLE_BITS-1) is pi) and ellipsoidal height in mm
// give X, Y, Z in mm on the ellipsoid held in the csr register (0 Corrego
// Alegre, 1 SAD69, 2 or 3 SIRGAS2000, reset SIRGAS2000). A new point is
// taken every cycle unless req_stall is high; the pipeline depth is set by
// the cordic stages, the one-bit-per-stage square root and the 52 quotient
// stages for the prime-vertical radius. A stall on the result side freezes
// the whole pipeline. Write the csr only while no point is in flight.
module geodetic_to_ecef_unit #(
   parameter int ANGLE_BITS = g2e_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [ANGLE_BITS-1:0]        req_latitude,
   input  wire logic signed [ANGLE_BITS-1:0]        req_longitude,
   input  wire logic signed [g2e_pkg::HEIGHT_W-1:0] req_height,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [g2e_pkg::COORD_W-1:0]       rsp_x_coord,
   output logic signed [g2e_pkg::COORD_W-1:0]       rsp_y_coord,
   output logic signed [g2e_pkg::COORD_W-1:0]       rsp_z_coord,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [g2e_pkg::SEL_W-1:0]           csr_ellipsoid
);
   import g2e_pkg::*;

   localparam int CARRY_N = 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int VLAT    = 1 + CORDIC_LAT + CARRY_N + 1 + 4;

   logic                     en;
   logic [SEL_W-1:0]         ellipsoid_ff;
   logic [VLAT-1:0]          vld_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              lat_turn, lon_turn;
   logic [31:0]              lat_turn_ff, lon_turn_ff;
   logic signed [HEIGHT_W-1:0] h_ff [CORDIC_LAT+1];
   logic signed [31:0]       slat, clat, slon, clon;
   trig_type                 carry_ff [CARRY_N];
   logic [63:0]              slat_sq;
   logic [30:0]              s2_ff;
   logic [64:0]              e2s2;
   logic [62:0]              t_ff;
   logic [62:0]              n_ff [SQRT_STEPS+1];
   logic [62:0]              res_ff [SQRT_STEPS+1];
   logic [31:0]              r_in;
   logic [32:0]              a_mm;
   logic [33:0]              e2;
   logic [33:0]              rem_ff [DIV_STEPS+1];
   logic [51:0]              q_ff [DIV_STEPS+1];
   logic [31:0]              dr_ff [DIV_STEPS+1];
   logic [49:0]              nq_ff;
   logic [58:0]              pp_lo_ff, pp_hi_ff;
   logic [83:0]              ne_sum;
   logic [43:0]              ne;
   logic signed [51:0]       h_wide;
   logic signed [51:0]       nh_ff, zh_ff;
   trig_type                 trig_nz_ff;
   trig_type                 lon_d_ff [2];
   logic signed [53:0]       p_q, zp_q;
   logic signed [53:0]       zp_d_ff [2];
   logic signed [55:0]       x_q, y_q;
   logic signed [55:0]       x_rnd, y_rnd;
   logic signed [53:0]       z_rnd;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en || reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ellipsoid_ff <= ELL_RESET;
      end else if (csr_valid && csr_ready) begin
         ellipsoid_ff <= csr_ellipsoid;
      end
   end

   assign a_mm = semi_major(ellipsoid_ff);
   assign e2   = ecc_sq(ellipsoid_ff);

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[VLAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VLAT-1];
      end
   end

   if (ANGLE_BITS >= 32) begin : g_wide
      assign lat_turn = req_latitude[ANGLE_BITS-1 -: 32];
      assign lon_turn = req_longitude[ANGLE_BITS-1 -: 32];
   end else begin : g_narrow
      assign lat_turn = {req_latitude, (32-ANGLE_BITS)'(0)};
      assign lon_turn = {req_longitude, (32-ANGLE_BITS)'(0)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lat_turn_ff <= lat_turn;
         lon_turn_ff <= lon_turn;
         h_ff[0]     <= req_height;
      end
   end

   for (genvar i = 0; i < CORDIC_LAT; i++) begin : g_hdly
      always_ff @(posedge clock) begin
         if (en) h_ff[i+1] <= h_ff[i];
      end
   end

   g2e_cordic u_cordic_lat (
      .clock (clock),
      .en    (en),
      .turn  (lat_turn_ff),
      .sin_q (slat),
      .cos_q (clat)
   );

   g2e_cordic u_cordic_lon (
      .clock (clock),
      .en    (en),
      .turn  (lon_turn_ff),
      .sin_q (slon),
      .cos_q (clon)
   );

   // sin^2 and the radicand
   assign slat_sq = unsigned'(64'(slat) * 64'(slat));
   assign e2s2    = 65'(e2) * 65'(s2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff      <= slat_sq[60:30];
         carry_ff[0] <= '{slat: slat, clat: clat, slon: slon, clon: clon,
                          height: h_ff[CORDIC_LAT]};
         t_ff       <= {1'b1, 62'd0} - 63'(e2s2 >> 8);
      end
   end

   for (genvar i = 1; i < CARRY_N; i++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en) carry_ff[i] <= carry_ff[i-1];
      end
   end

   // square root, one result bit per stage
   assign n_ff[0]   = t_ff;
   assign res_ff[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2*k);
      logic [63:0] trial;
      assign trial = {1'b0, res_ff[k]} + SQ_BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if ({1'b0, n_ff[k]} >= trial) begin
               n_ff[k+1]   <= n_ff[k] - trial[62:0];
               res_ff[k+1] <= (res_ff[k] >> 1) + SQ_BIT[62:0];
            end else begin
               n_ff[k+1]   <= n_ff[k];
               res_ff[k+1] <= res_ff[k] >> 1;
            end
         end
      end
   end

   assign r_in = res_ff[SQRT_STEPS][31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         dr_ff[0]  <= (r_in == '0) ? 32'd1 : r_in;
         rem_ff[0] <= 34'(a_mm[32:5]);
         q_ff[0]   <= '0;
      end
   end

   // n = a * 2^47 / r, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic        num_bit;
      logic [33:0] rem_sh;
      logic        ge;
      if (j <= 4) begin : g_abit
         assign num_bit = a_mm[4-j];
      end else begin : g_zbit
         assign num_bit = 1'b0;
      end
      assign rem_sh = {rem_ff[j][32:0], num_bit};
      assign ge     = rem_sh >= {2'b00, dr_ff[j]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_sh - {2'b00, dr_ff[j]} : rem_sh;
            q_ff[j+1]   <= {q_ff[j][50:0], ge};
            dr_ff[j+1]  <= dr_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq_ff    <= q_ff[DIV_STEPS][49:0];
         pp_lo_ff <= 59'(q_ff[DIV_STEPS][24:0]) * 59'(e2);
         pp_hi_ff <= 59'(q_ff[DIV_STEPS][49:25]) * 59'(e2);
      end
   end

   assign ne_sum = {pp_hi_ff, 25'd0} + 84'(pp_lo_ff);
   assign ne     = ne_sum[83:40];
   assign h_wide = 52'(carry_ff[CARRY_N-1].height) <<< 16;

   always_ff @(posedge clock) begin
      if (en) begin
         nh_ff      <= signed'({2'b00, nq_ff}) + h_wide;
         zh_ff      <= signed'({2'b00, nq_ff}) - signed'(52'(ne)) + h_wide;
         trig_nz_ff <= carry_ff[CARRY_N-1];
         lon_d_ff[0] <= trig_nz_ff;
         lon_d_ff[1] <= lon_d_ff[0];
         zp_d_ff[0]  <= zp_q;
         zp_d_ff[1]  <= zp_d_ff[0];
      end
   end

   g2e_smul #(.A_W(52)) u_mul_p (
      .clock (clock), .en (en), .a (nh_ff), .b (trig_nz_ff.clat), .prod (p_q)
   );

   g2e_smul #(.A_W(52)) u_mul_z (
      .clock (clock), .en (en), .a (zh_ff), .b (trig_nz_ff.slat), .prod (zp_q)
   );

   g2e_smul #(.A_W(54)) u_mul_x (
      .clock (clock), .en (en), .a (p_q), .b (lon_d_ff[1].clon), .prod (x_q)
   );

   g2e_smul #(.A_W(54)) u_mul_y (
      .clock (clock), .en (en), .a (p_q), .b (lon_d_ff[1].slon), .prod (y_q)
   );

   // round q16 to whole mm, halves upward
   assign x_rnd = (x_q + 56'sd32768) >>> 16;
   assign y_rnd = (y_q + 56'sd32768) >>> 16;
   assign z_rnd = (zp_d_ff[1] + 54'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_rnd[COORD_W-1:0];
         y_ff <= y_rnd[COORD_W-1:0];
         z_ff <= z_rnd[COORD_W-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_coord = x_ff;
   assign rsp_y_coord = y_ff;
   assign rsp_z_coord = z_ff;

   a_empty_quiet: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0 && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result transfer with no point in flight");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> ellipsoid_ff == $past(csr_ellipsoid))
      else $error("ellipsoid register missed a write");

endmodule
`default_nettype wire
